// ----- design/snsq_pkg.sv -----
// Shared types and constants for the sorted note sequencer.
package snsq_pkg;

  typedef enum logic [2:0] {
    CMD_TOGGLE = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_TRIM   = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_IDX_M1,
    ADDR_NEXT
  } addr_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEL_RD,
    S_DEL_CMP,
    S_DEL_END,
    S_INS_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_INS_END,
    S_TRIM_RD,
    S_TRIM_CMP,
    S_TRIM_END,
    S_TICK_CHK,
    S_TICK_DIV,
    S_TICK_PH,
    S_TICK_RD,
    S_TICK_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       latch_in;
    logic       idx_clr;
    logic       idx_load_count;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    logic       wr_p;
    logic       found_set;
    logic       del_commit;
    logic       ins_commit;
    logic       trim_commit;
    logic       status_set;
    logic [1:0] status_code;
    logic       div_load;
    logic       div_step;
    logic       phase_commit;
    logic       next_clr;
    logic       fire_commit;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_eq_count;
    logic idx_zero;
    logic found;
    logic rd_eq_p;
    logic rd_gt_p;
    logic rd_ge_end;
    logic full;
    logic count_zero;
    logic none_pending;
    logic phase_lt_prev;
    logic div_last;
    logic phase_ge_rd;
  } dp_sts_t;

endpackage

// ----- design/snsq_channels.sv -----
// Valid/ready channel interfaces for command words and result words.
interface snsq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] note_position;
  logic [23:0] beat_time;

  modport source (output valid, cmd, note_position, beat_time, input ready);
  modport sink   (input valid, cmd, note_position, beat_time, output ready);
endinterface

interface snsq_out_if;
  logic       valid;
  logic       ready;
  logic       fire;
  logic [1:0] status;
  logic [5:0] note_count;

  modport source (output valid, fire, status, note_count, input ready);
  modport sink   (input valid, fire, status, note_count, output ready);
endinterface

// ----- design/snsq_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module snsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- design/snsq_ctrl.sv -----
// Controller state machine: sequences table walks, division and result hand-off.
module snsq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  snsq_pkg::dp_sts_t sts,
  output snsq_pkg::dp_cmd_t cmd
);
  snsq_pkg::state_t state, state_next;
  logic is_toggle;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= snsq_pkg::S_IDLE;
      out_valid <= 1'b0;
      is_toggle <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cmd.latch_in) begin
        is_toggle <= (in_cmd == snsq_pkg::CMD_TOGGLE);
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      snsq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.idx_clr  = 1'b1;
          unique case (in_cmd)
            snsq_pkg::CMD_TOGGLE, snsq_pkg::CMD_REMOVE: state_next = snsq_pkg::S_DEL_RD;
            snsq_pkg::CMD_ADD:  state_next = snsq_pkg::S_INS_CHK;
            snsq_pkg::CMD_TICK: state_next = snsq_pkg::S_TICK_CHK;
            snsq_pkg::CMD_TRIM: state_next = snsq_pkg::S_TRIM_RD;
            default:            state_next = snsq_pkg::S_DONE;
          endcase
        end
      end
      snsq_pkg::S_DEL_RD: begin
        if (sts.idx_eq_count) begin
          state_next = snsq_pkg::S_DEL_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = snsq_pkg::ADDR_IDX;
          state_next = snsq_pkg::S_DEL_CMP;
        end
      end
      snsq_pkg::S_DEL_CMP: begin
        // after the match, pull every later entry down by one
        if (sts.found) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = snsq_pkg::ADDR_IDX_M1;
          cmd.idx_inc = 1'b1;
          state_next  = snsq_pkg::S_DEL_RD;
        end else if (sts.rd_eq_p) begin
          cmd.found_set = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = snsq_pkg::S_DEL_RD;
        end else if (sts.rd_gt_p) begin
          state_next = snsq_pkg::S_DEL_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = snsq_pkg::S_DEL_RD;
        end
      end
      snsq_pkg::S_DEL_END: begin
        if (sts.found) begin
          cmd.del_commit = 1'b1;
          state_next     = snsq_pkg::S_DONE;
        end else if (is_toggle) begin
          state_next = snsq_pkg::S_INS_CHK;
        end else begin
          cmd.status_set  = 1'b1;
          cmd.status_code = snsq_pkg::ST_NOMATCH;
          state_next      = snsq_pkg::S_DONE;
        end
      end
      snsq_pkg::S_INS_CHK: begin
        if (sts.full) begin
          cmd.status_set  = 1'b1;
          cmd.status_code = snsq_pkg::ST_FULL;
          state_next      = snsq_pkg::S_DONE;
        end else begin
          cmd.idx_load_count = 1'b1;
          state_next         = snsq_pkg::S_INS_RD;
        end
      end
      snsq_pkg::S_INS_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = snsq_pkg::ADDR_IDX;
          cmd.wr_p   = 1'b1;
          state_next = snsq_pkg::S_INS_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = snsq_pkg::ADDR_IDX_M1;
          state_next = snsq_pkg::S_INS_CMP;
        end
      end
      snsq_pkg::S_INS_CMP: begin
        // walk down from the top, shifting larger entries up one slot
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = snsq_pkg::ADDR_IDX;
        if (sts.rd_gt_p) begin
          cmd.idx_dec = 1'b1;
          state_next  = snsq_pkg::S_INS_RD;
        end else begin
          cmd.wr_p   = 1'b1;
          state_next = snsq_pkg::S_INS_END;
        end
      end
      snsq_pkg::S_INS_END: begin
        cmd.ins_commit = 1'b1;
        state_next     = snsq_pkg::S_DONE;
      end
      snsq_pkg::S_TRIM_RD: begin
        if (sts.idx_eq_count) begin
          state_next = snsq_pkg::S_TRIM_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = snsq_pkg::ADDR_IDX;
          state_next = snsq_pkg::S_TRIM_CMP;
        end
      end
      snsq_pkg::S_TRIM_CMP: begin
        if (sts.rd_ge_end) begin
          state_next = snsq_pkg::S_TRIM_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = snsq_pkg::S_TRIM_RD;
        end
      end
      snsq_pkg::S_TRIM_END: begin
        cmd.trim_commit = 1'b1;
        state_next      = snsq_pkg::S_DONE;
      end
      snsq_pkg::S_TICK_CHK: begin
        if (sts.count_zero) begin
          state_next = snsq_pkg::S_DONE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = snsq_pkg::S_TICK_DIV;
        end
      end
      snsq_pkg::S_TICK_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = snsq_pkg::S_TICK_PH;
        end
      end
      snsq_pkg::S_TICK_PH: begin
        cmd.phase_commit = 1'b1;
        if (!sts.none_pending) begin
          state_next = snsq_pkg::S_TICK_RD;
        end else if (sts.phase_lt_prev) begin
          cmd.next_clr = 1'b1;
          state_next   = snsq_pkg::S_TICK_RD;
        end else begin
          state_next = snsq_pkg::S_DONE;
        end
      end
      snsq_pkg::S_TICK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = snsq_pkg::ADDR_NEXT;
        state_next = snsq_pkg::S_TICK_CMP;
      end
      snsq_pkg::S_TICK_CMP: begin
        if (sts.phase_ge_rd) begin
          cmd.fire_commit = 1'b1;
        end
        state_next = snsq_pkg::S_DONE;
      end
      snsq_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = snsq_pkg::S_IDLE;
        end
      end
      default: state_next = snsq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end
endmodule

// ----- design/snsq_datapath.sv -----
// Datapath: note table, counters, loop-length register, phase divider, result register.
module snsq_datapath #(
  parameter int MAX_NOTES = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic [15:0]       note_position,
  input  logic [23:0]       beat_time,
  input  snsq_pkg::dp_cmd_t cmd,
  output snsq_pkg::dp_sts_t sts,
  output logic              fire,
  output logic [1:0]        status,
  output logic [5:0]        note_count
);
  localparam int AW   = $clog2(MAX_NOTES);
  localparam int IW   = $clog2(MAX_NOTES + 1);
  localparam int PH_W = 8 + FRAC_BITS;
  localparam int Q_W  = 24 - FRAC_BITS;
  localparam int SW   = $clog2(Q_W + 1);
  localparam logic [23:0] FRAC_MASK = (24'd1 << FRAC_BITS) - 24'd1;

  logic [7:0]      loop_length;
  logic [IW-1:0]   count;
  logic [IW-1:0]   next_idx;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   idx_m1;
  logic [IW-1:0]   where;
  logic            found;
  logic [PH_W-1:0] last_phase;
  logic [15:0]     pos_p;
  logic [23:0]     beat;
  logic [7:0]      rem;
  logic [Q_W-1:0]  qsh;
  logic [SW-1:0]   steps;
  logic            fire_w;
  logic [1:0]      status_w;

  logic [8:0]      loop_beats;
  logic [31:0]     loop_end;
  logic [8:0]      rem_shift;
  logic [7:0]      rem_next;
  logic [PH_W-1:0] phase;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [15:0]     wr_data;
  logic [15:0]     rd_data;

  // a zero register means 256 beats
  assign loop_beats = {loop_length == 8'd0, loop_length};
  assign loop_end   = 32'(loop_beats) << FRAC_BITS;
  assign idx_m1     = idx - IW'(1);

  // one restoring division step on the whole-beat part
  assign rem_shift = {rem, qsh[Q_W-1]};
  assign rem_next  = (rem_shift >= loop_beats) ? 8'(rem_shift - loop_beats) : rem_shift[7:0];
  assign phase     = (PH_W'(rem) << FRAC_BITS) | PH_W'(beat & FRAC_MASK);

  always_comb begin
    unique case (cmd.rd_sel)
      snsq_pkg::ADDR_IDX:    rd_addr = idx[AW-1:0];
      snsq_pkg::ADDR_IDX_M1: rd_addr = idx_m1[AW-1:0];
      snsq_pkg::ADDR_NEXT:   rd_addr = next_idx[AW-1:0];
      default:               rd_addr = idx[AW-1:0];
    endcase
    unique case (cmd.wr_sel)
      snsq_pkg::ADDR_IDX:    wr_addr = idx[AW-1:0];
      snsq_pkg::ADDR_IDX_M1: wr_addr = idx_m1[AW-1:0];
      snsq_pkg::ADDR_NEXT:   wr_addr = next_idx[AW-1:0];
      default:               wr_addr = idx[AW-1:0];
    endcase
  end

  assign wr_data = cmd.wr_p ? pos_p : rd_data;

  snsq_ram #(
    .WIDTH (16),
    .DEPTH (MAX_NOTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    sts.idx_eq_count  = (idx == count);
    sts.idx_zero      = (idx == '0);
    sts.found         = found;
    sts.rd_eq_p       = (rd_data == pos_p);
    sts.rd_gt_p       = (rd_data > pos_p);
    sts.rd_ge_end     = (32'(rd_data) >= loop_end);
    sts.full          = (count >= IW'(MAX_NOTES));
    sts.count_zero    = (count == '0);
    sts.none_pending  = (next_idx >= count);
    sts.phase_lt_prev = (phase < last_phase);
    sts.div_last      = (steps == SW'(Q_W - 1));
    sts.phase_ge_rd   = (32'(last_phase) >= 32'(rd_data));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= 8'd4;
      count       <= '0;
      next_idx    <= '0;
      last_phase  <= '0;
      found       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        loop_length <= cfg_wr_data;
      end
      if (cmd.latch_in) begin
        found <= 1'b0;
      end else if (cmd.found_set) begin
        found <= 1'b1;
      end
      if (cmd.phase_commit) begin
        last_phase <= phase;
      end
      if (cmd.del_commit) begin
        count <= count - IW'(1);
        if (next_idx > where) begin
          next_idx <= next_idx - IW'(1);
        end
      end else if (cmd.ins_commit) begin
        count <= count + IW'(1);
        if (next_idx >= count) begin
          next_idx <= '0;
        end else if (idx <= next_idx) begin
          next_idx <= next_idx + IW'(1);
        end
      end else if (cmd.trim_commit) begin
        count <= idx;
        if (next_idx > idx) begin
          next_idx <= idx;
        end
      end else if (cmd.next_clr) begin
        next_idx <= '0;
      end else if (cmd.fire_commit) begin
        next_idx <= next_idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pos_p    <= note_position;
      beat     <= beat_time;
      fire_w   <= 1'b0;
      status_w <= snsq_pkg::ST_DONE;
    end else begin
      if (cmd.status_set) begin
        status_w <= cmd.status_code;
      end
      if (cmd.fire_commit) begin
        fire_w <= 1'b1;
      end
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_load_count) begin
      idx <= count;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
    if (cmd.found_set) begin
      where <= idx;
    end
    if (cmd.div_load) begin
      rem   <= '0;
      qsh   <= Q_W'(beat >> FRAC_BITS);
      steps <= '0;
    end else if (cmd.div_step) begin
      rem   <= rem_next;
      qsh   <= qsh << 1;
      steps <= steps + SW'(1);
    end
    if (cmd.out_load) begin
      fire       <= fire_w;
      status     <= status_w;
      note_count <= 6'(count);
    end
  end
endmodule

// ----- design/sorted_note_sequencer.sv -----
// Top level of the sorted note sequencer: controller, datapath and checks.
//
//   channel  | dir | payload                          | handshake
//   item     | in  | cmd, note_position, beat_time    | valid/ready
//   result   | out | fire, status, note_count         | valid/ready
//   cfg      | in  | cfg_wr_data (loop_length)        | cfg_wr_en, no wait
//
// One word is worked at a time; the note table is a single-port-read RAM walked
// entry by entry through a read state and a compare state. Tick runs the
// bit-serial phase divider. A finished result sits in the output register while
// the next word is accepted; a stalled result holds the last state only.
// Reset clears the count, the next-note index and the phase; table contents are not cleared.
module sorted_note_sequencer #(
  parameter int MAX_NOTES = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  snsq_in_if.sink    item,
  snsq_out_if.source result
);
  snsq_pkg::dp_cmd_t dp_cmd;
  snsq_pkg::dp_sts_t dp_sts;

  snsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_cmd    (item.cmd),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  snsq_datapath #(
    .MAX_NOTES (MAX_NOTES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .note_position (item.note_position),
    .beat_time     (item.beat_time),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .fire          (result.fire),
    .status        (result.status),
    .note_count    (result.note_count)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("new word accepted while one is in work");

  a_fire_is_done: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fire |-> result.status == snsq_pkg::ST_DONE)
    else $error("fire with a non-done status");

  a_insert_has_room: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.ins_commit |-> !dp_sts.full)
    else $error("insert committed into a full table");
`endif
endmodule
